// File: sv/postfix_stack_evaluator_core_macros.svh
// Assertion macros for the postfix evaluator
`ifndef POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PSE_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PSE_ASSERT_IMP(label, clk, rst_n, a, c)
`define PSE_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: sv/pse_pkg.sv
`timescale 1ns / 1ps
package pse_pkg;
  localparam logic [7:0] SYM_POW = 8'h5E;
  localparam logic [7:0] SYM_MUL = 8'h2A;
  localparam logic [7:0] SYM_DIV = 8'h2F;
  localparam logic [7:0] SYM_MOD = 8'h25;
  localparam logic [7:0] SYM_SUB = 8'h2D;
  localparam logic [7:0] SYM_ADD = 8'h2B;
  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_MATH = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE, OP_POW, OP_MUL, OP_DIV, OP_MOD, OP_SUB, OP_ADD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_FIN, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch incoming request
    logic       rd_start;  // read top two entries
    logic       exec;      // launch arithmetic
    logic       finish;    // apply result / push / emit
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic can_op;
    logic multi;   // operation uses the iterative unit
    logic done;    // iterative unit finished
    logic last;
  } sts_t;
endpackage

// File: sv/pse_ctrl.sv
`timescale 1ns / 1ps
module pse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pse_pkg::sts_t   sts,
  output pse_pkg::cmd_t   cmd
);
  import pse_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // top two entries are always fetched; the top also feeds the result
        cmd.rd_start = 1'b1;
        if (sts.is_op && sts.can_op) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.multi ? S_WAIT : S_FIN;
      end
      S_WAIT: if (sts.done) state_nxt = S_FIN;
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = sts.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: sv/pse_iter.sv
`timescale 1ns / 1ps
// Iterative divide (restoring, 1 bit/cycle) and power (square-multiply, 1 bit/cycle)
module pse_iter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_pow,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem,
  output logic [31:0] pw
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        pow_r;
  logic [31:0] a_r, a_nxt;     // dividend shift / base
  logic [31:0] b_r;            // divisor magnitude
  logic [32:0] r_r, r_nxt;     // partial remainder
  logic [31:0] e_r, e_nxt;     // exponent
  logic [31:0] acc_r, acc_nxt;
  logic        xneg_r, yneg_r;
  logic [32:0] trial;
  logic [31:0] q_mag, r_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pow_r <= is_pow;
      xneg_r <= x[31];
      yneg_r <= y[31];
      a_r <= is_pow ? x : (x[31] ? 32'(-x) : x);
      b_r <= y[31] ? 32'(-y) : y;
      r_r <= '0;
      e_r <= y;
      acc_r <= 32'd1;
    end else begin
      a_r <= a_nxt;
      r_r <= r_nxt;
      e_r <= e_nxt;
      acc_r <= acc_nxt;
    end
  end

  // one step per cycle, 32 steps, then one cycle with done
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    a_nxt = a_r;
    r_nxt = r_r;
    e_nxt = e_r;
    acc_nxt = acc_r;
    trial = {r_r[31:0], a_r[31]} - {1'b0, b_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
      end else begin
        if (pow_r) begin
          if (e_r[0]) acc_nxt = acc_r * a_r;
          a_nxt = a_r * a_r;
          e_nxt = e_r >> 1;
        end else begin
          if (!trial[32]) begin
            r_nxt = trial;
            a_nxt = {a_r[30:0], 1'b1};
          end else begin
            r_nxt = {r_r[31:0], a_r[31]};
            a_nxt = {a_r[30:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  assign done = busy_r && (cnt_r == 6'd32);
  assign q_mag = a_r;
  assign r_mag = r_r[31:0];
  assign quo = (xneg_r ^ yneg_r) ? 32'(-q_mag) : q_mag;
  assign rem = xneg_r ? 32'(-r_mag) : r_mag;
  assign pw = acc_r;
endmodule

// File: sv/pse_dp.sv
`timescale 1ns / 1ps
module pse_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_symbol,
  input  logic          in_last,
  input  pse_pkg::cmd_t cmd,
  output pse_pkg::sts_t sts,
  output logic [31:0]   out_value,
  output logic [1:0]    out_status
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [PW-1:0] sp_r, sp_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [7:0]    sym_r;
  logic          last_r;
  op_t           op;
  logic [31:0]   x_r, y_r, res_r;
  logic [31:0]   value_r;
  logic [1:0]    status_r;
  logic          merr_r;
  logic          it_start, it_done;
  logic [31:0]   quo, rem, pw;
  logic [AW-1:0] top_idx, sec_idx, wr_idx;
  logic          we;
  logic [31:0]   wdata;
  logic [31:0]   res_c;
  logic          merr_c;
  logic          is_digit;
  logic [PW-1:0] sp_nxt_pre;
  logic [1:0]    err_pre;
  logic [31:0]   wv_top;

  // decode latched symbol
  always_comb begin
    unique case (sym_r)
      SYM_POW: op = OP_POW;
      SYM_MUL: op = OP_MUL;
      SYM_DIV: op = OP_DIV;
      SYM_MOD: op = OP_MOD;
      SYM_SUB: op = OP_SUB;
      SYM_ADD: op = OP_ADD;
      default: op = OP_NONE;
    endcase
  end

  assign is_digit = (sym_r >= SYM_ZERO) && (sym_r <= SYM_NINE);
  assign top_idx = AW'(sp_r - PW'(1));
  assign sec_idx = AW'(sp_r - PW'(2));

  assign sts.is_digit = is_digit;
  assign sts.is_op = (op != OP_NONE) && !is_digit;
  assign sts.can_op = (sp_r >= PW'(2));
  assign sts.multi = (op == OP_POW && !y_r[31]) || ((op == OP_DIV || op == OP_MOD) &&
                     y_r != 32'd0 && !(x_r == 32'h8000_0000 && y_r == 32'hFFFF_FFFF));
  assign sts.done = it_done;
  assign sts.last = last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_r <= in_symbol;
      last_r <= in_last;
    end
  end

  // operand reads
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      y_r <= mem[top_idx];
      x_r <= mem[sec_idx];
    end
  end

  // combinational results and special cases
  always_comb begin
    res_c = '0;
    merr_c = 1'b0;
    case (op)
      OP_ADD: res_c = x_r + y_r;
      OP_SUB: res_c = x_r - y_r;
      OP_MUL: res_c = x_r * y_r;
      OP_POW: begin
        if (x_r == 32'd1) res_c = 32'd1;
        else if (x_r == 32'hFFFF_FFFF) res_c = y_r[0] ? 32'hFFFF_FFFF : 32'd1;
        else begin
          res_c = '0;
          // zero to a negative power
          merr_c = y_r[31] && (x_r == 32'd0);
        end
      end
      OP_DIV, OP_MOD: begin
        merr_c = (y_r == 32'd0);
        res_c = (op == OP_DIV && y_r != 32'd0) ? 32'h8000_0000 : 32'd0;
      end
      default: res_c = '0;
    endcase
  end

  assign it_start = cmd.exec && sts.multi;

  pse_iter u_iter (
    .clk(clk), .rst_n(rst_n), .start(it_start), .is_pow(op == OP_POW),
    .x(x_r), .y(y_r), .done(it_done), .quo(quo), .rem(rem), .pw(pw)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_c;
      merr_r <= merr_c;
    end else if (it_done) begin
      res_r <= (op == OP_POW) ? pw : (op == OP_DIV) ? quo : rem;
    end
  end

  // stack write and pointer update
  always_comb begin
    sp_nxt = sp_r;
    err_nxt = err_r;
    we = 1'b0;
    wr_idx = top_idx;
    wdata = res_r;
    if (cmd.finish) begin
      if (is_digit) begin
        if (sp_r < PW'(STACK_DEPTH)) begin
          we = 1'b1;
          wr_idx = AW'(sp_r);
          wdata = {28'd0, 4'(sym_r - SYM_ZERO)};
          sp_nxt = sp_r + PW'(1);
        end else if (err_r == ST_OK) begin
          err_nxt = ST_OVERFLOW;
        end
      end else if (sts.is_op && sts.can_op) begin
        we = 1'b1;
        wr_idx = sec_idx;
        sp_nxt = sp_r - PW'(1);
        if (merr_r && err_r == ST_OK) err_nxt = ST_MATH;
      end
      if (last_r) begin
        sp_nxt = '0;
        err_nxt = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_idx] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      err_r <= ST_OK;
    end else begin
      sp_r <= sp_nxt;
      err_r <= err_nxt;
    end
  end

  // state as it stands after this symbol, before the clear
  always_comb begin
    sp_nxt_pre = sp_r;
    err_pre = err_r;
    wv_top = (sp_r == '0) ? 32'd0 : y_r;
    if (is_digit) begin
      if (sp_r < PW'(STACK_DEPTH)) begin
        sp_nxt_pre = sp_r + PW'(1);
        wv_top = {28'd0, 4'(sym_r - SYM_ZERO)};
      end else if (err_r == ST_OK) begin
        err_pre = ST_OVERFLOW;
      end
    end else if (sts.is_op && sts.can_op) begin
      sp_nxt_pre = sp_r - PW'(1);
      wv_top = res_r;
      if (merr_r && err_r == ST_OK) err_pre = ST_MATH;
    end
  end

  // result register, captured when finishing the last symbol
  always_ff @(posedge clk) begin
    if (cmd.finish && last_r) begin
      if (sp_nxt_pre == '0) value_r <= '0;
      else value_r <= wv_top;
      if (err_pre != ST_OK) status_r <= err_pre;
      else if (sp_nxt_pre == '0) status_r <= ST_EMPTY;
      else status_r <= ST_OK;
    end
  end

  assign out_value = value_r;
  assign out_status = status_r;
endmodule

// File: sv/postfix_stack_evaluator_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                          | Direction
// in       | in_valid in_stall in_symbol in_last | request in
// out      | out_valid out_stall out_value out_status | request out
// Digits, ignored symbols and operators short of operands pass through IDLE, READ and FIN.
// + - * and the / % ^ cases settled at once (zero divisor, negative exponent,
//   most negative by -1) also pass through EXEC between READ and FIN.
// Other / % ^ also wait in WAIT through the 32 steps of the iterative unit until done.
// A last request adds OUT, held while out_stall is high.
// rst_n is synchronous; it empties the stack and clears the error.
// No new request is taken until the previous one is finished.
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]  out_status
);
  import pse_pkg::*;
`include "postfix_stack_evaluator_core_macros.svh"

  cmd_t cmd;
  sts_t sts;
  logic [31:0] value_w;

  pse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  pse_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_symbol(in_symbol), .in_last(in_last),
    .cmd(cmd), .sts(sts), .out_value(value_w), .out_status(out_status)
  );

  assign out_value = value_w;

  `PSE_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, in_stall)
  `PSE_ASSERT_NXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `PSE_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.capture, cmd.exec, cmd.finish}))
endmodule
